[design/i2cm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types, command codes and widths for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Width of the segment tick counter.
    localparam int unsigned COUNT_WIDTH = 16;

    // Width of the half period register, and its value after reset.
    localparam int unsigned HALF_WIDTH = 16;
    localparam logic [HALF_WIDTH-1:0] HALF_RESET = HALF_WIDTH'(10);

    // Nine bit slots per byte: eight data bits and the acknowledge bit.
    localparam logic [3:0] ACK_SLOT = 4'd8;

    // Stream payload widths.
    localparam int unsigned S_TDATA_WIDTH = 16;
    localparam int unsigned M_TDATA_WIDTH = 16;
    localparam int unsigned OP_WIDTH      = 3;

    // Configuration register indexes.
    localparam logic REG_HALF_PERIOD = 1'b0;

    // Commands carried on the input stream.
    typedef enum logic [OP_WIDTH-1:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_ADDR  = 3'd3,
        OP_WRITE = 3'd4,
        OP_READ  = 3'd5
    } t_op;

    // Pin sequencer phases.
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_START_A  = 3'd1,
        PH_START_B  = 3'd2,
        PH_STOP_A   = 3'd3,
        PH_STOP_B   = 3'd4,
        PH_BIT_LOW  = 3'd5,
        PH_BIT_HIGH = 3'd6
    } t_phase;

endpackage : i2cm_pkg
`default_nettype wire

[design/i2c_master_byte_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master byte engine
// Drives SCL and SDA for start, stop, address, write and read commands.
// Each input transaction is one timing tick; each tick gives one result.
// ----------------------------------------------------------------------------
// Results: each result is registered on the clock edge that accepts its tick.
// Throughput: one tick per cycle; the sequencer state and the result register
// update together, and the input stays ready while the result register is
// empty or being drained.
// Reset: synchronous, active low; the sequencer is idle with both lines
// released, the half period is 10 ticks and no result is pending.
module i2c_master_byte_engine (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input tick stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [7:0] data, [8] rw, [9] sda_in, [15:10] zero
    input  wire logic [i2cm_pkg::S_TDATA_WIDTH-1:0] s_axis_tdata,
    // [2:0] op
    input  wire logic [i2cm_pkg::OP_WIDTH-1:0]      s_axis_tuser,
    // Read ending: 1 sends nack after the byte, 0 sends ack
    input  wire logic                               s_axis_tlast,
    // Result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [0] scl, [1] sda_out, [2] busy_res, [3] done_res, [11:4] read_data,
    // [12] ack, [15:13] zero
    output logic [i2cm_pkg::M_TDATA_WIDTH-1:0]      m_axis_tdata,
    // Configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import i2cm_pkg::*;

    // Input fields.
    t_op                   w_op;
    logic [7:0]            w_data;
    logic                  w_rw;
    logic                  w_last;
    logic                  w_sda_in;
    logic                  w_accept;

    // Sequencer state.
    t_phase                r_phase,    n_phase;
    logic [3:0]            r_bit_idx,  n_bit_idx;
    logic [7:0]            r_shift,    n_shift;
    logic [COUNT_WIDTH-1:0] r_tick,    n_tick;
    logic [7:0]            r_rx_byte,  n_rx_byte;
    logic                  r_ack,      n_ack;
    logic                  r_scl,      n_scl;
    logic                  r_sda,      n_sda;
    t_op                   r_cur_op,   n_cur_op;
    logic                  r_nack,     n_nack;
    logic                  n_done;

    logic [HALF_WIDTH-1:0] r_half;
    logic [COUNT_WIDTH-1:0] w_limit;
    logic                  w_seg_end;
    logic                  w_cmd_valid;

    // Result register.
    logic                  r_out_valid;
    logic [M_TDATA_WIDTH-1:0] r_out_data;

    // SDA level in a bit low segment, given the slot and the byte being shifted.
    function automatic logic low_sda(input logic [3:0] idx, input logic [7:0] shift,
                                     input t_op op, input logic nack);
        logic v;
        if (idx < ACK_SLOT) begin
            v = (op == OP_READ) ? 1'b1 : shift[7];
        end else begin
            v = (op == OP_READ) ? nack : 1'b1;
        end
        return v;
    endfunction

    // Unpack the input transaction.
    always_comb begin
        w_op     = t_op'(s_axis_tuser);
        w_data   = s_axis_tdata[7:0];
        w_rw     = s_axis_tdata[8];
        w_sda_in = s_axis_tdata[9];
        w_last   = s_axis_tlast;
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Configuration port: one register, writes always complete at once.
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_HALF_PERIOD) begin
            prdata = {{(32-HALF_WIDTH){1'b0}}, r_half};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_HALF_PERIOD) begin
            r_half <= pwdata[HALF_WIDTH-1:0];
        end
    end

    // Segment length: a zero half period counts as one tick.
    assign w_limit   = (r_half == '0) ? COUNT_WIDTH'(1) : COUNT_WIDTH'(r_half);
    assign w_seg_end = (r_tick >= w_limit);
    assign w_cmd_valid = (w_op == OP_START) || (w_op == OP_STOP) || (w_op == OP_ADDR)
                      || (w_op == OP_WRITE) || (w_op == OP_READ);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (w_op == OP_START) begin
                    n_phase = PH_START_A;
                end else if (w_op == OP_STOP) begin
                    n_phase = PH_STOP_A;
                end else if (w_cmd_valid) begin
                    n_phase = PH_BIT_LOW;
                end
            end
            PH_START_A:  if (w_seg_end) n_phase = PH_START_B;
            PH_START_B:  if (w_seg_end) n_phase = PH_IDLE;
            PH_STOP_A:   if (w_seg_end) n_phase = PH_STOP_B;
            PH_STOP_B:   if (w_seg_end) n_phase = PH_IDLE;
            PH_BIT_LOW:  if (w_seg_end) n_phase = PH_BIT_HIGH;
            PH_BIT_HIGH: begin
                if (w_seg_end) begin
                    n_phase = (r_bit_idx < ACK_SLOT) ? PH_BIT_LOW : PH_IDLE;
                end
            end
            default:     n_phase = PH_IDLE;
        endcase
    end

    // Pin levels, shift register, counters and status for this tick.
    always_comb begin
        n_bit_idx = r_bit_idx;
        n_shift   = r_shift;
        n_tick    = r_tick;
        n_rx_byte = r_rx_byte;
        n_ack     = r_ack;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_cur_op  = r_cur_op;
        n_nack    = r_nack;
        n_done    = 1'b0;
        if (r_phase == PH_IDLE) begin
            // Take a new command.
            if (w_cmd_valid) begin
                n_cur_op = w_op;
                n_tick   = COUNT_WIDTH'(1);
                if (w_op == OP_START) begin
                    n_scl = 1'b1;
                    n_sda = 1'b1;
                end else if (w_op == OP_STOP) begin
                    n_scl = 1'b0;
                    n_sda = 1'b0;
                end else begin
                    n_bit_idx = '0;
                    if (w_op == OP_ADDR) begin
                        n_shift = {w_data[6:0], w_rw};
                    end else if (w_op == OP_WRITE) begin
                        n_shift = w_data;
                    end else begin
                        n_shift = '0;
                        n_nack  = w_last;
                    end
                    n_scl = 1'b0;
                    n_sda = low_sda(4'd0, n_shift, w_op, n_nack);
                end
            end
        end else if (w_seg_end) begin
            // End of a segment: move to the next one.
            n_tick = COUNT_WIDTH'(1);
            unique case (r_phase)
                PH_START_A, PH_STOP_A: begin
                    n_scl = 1'b1;
                    n_sda = 1'b0;
                end
                PH_START_B: begin
                    n_scl  = 1'b0;
                    n_sda  = 1'b0;
                    n_done = 1'b1;
                end
                PH_STOP_B: begin
                    n_scl  = 1'b1;
                    n_sda  = 1'b1;
                    n_done = 1'b1;
                end
                PH_BIT_LOW: begin
                    n_scl = 1'b1;
                end
                default: begin
                    if (r_bit_idx < ACK_SLOT) begin
                        n_shift   = {r_shift[6:0], w_sda_in};
                        n_bit_idx = r_bit_idx + 4'd1;
                        n_scl     = 1'b0;
                        n_sda     = low_sda(n_bit_idx, n_shift, r_cur_op, r_nack);
                    end else begin
                        if (r_cur_op == OP_READ) begin
                            n_rx_byte = r_shift;
                        end else begin
                            n_ack = w_sda_in;
                        end
                        n_scl  = 1'b0;
                        n_done = 1'b1;
                    end
                end
            endcase
            if (n_done) begin
                n_tick    = '0;
                n_bit_idx = '0;
            end
        end else begin
            n_tick = r_tick + COUNT_WIDTH'(1);
        end
    end

    // Sequencer registers advance once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit_idx <= '0;
            r_shift   <= '0;
            r_tick    <= '0;
            r_rx_byte <= '0;
            r_ack     <= 1'b1;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_cur_op  <= OP_NONE;
            r_nack    <= 1'b0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_bit_idx <= n_bit_idx;
            r_shift   <= n_shift;
            r_tick    <= n_tick;
            r_rx_byte <= n_rx_byte;
            r_ack     <= n_ack;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_cur_op  <= n_cur_op;
            r_nack    <= n_nack;
        end
    end

    // Result register, held until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {3'b000, n_ack, n_rx_byte, n_done,
                           (n_phase != PH_IDLE), n_sda, n_scl};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A completing tick never reports the engine as busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[2]))
        else $error("done and busy reported together");

    // The tick counter rests at zero while idle.
    a_idle_tick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_tick == '0 && r_bit_idx == '0))
        else $error("idle sequencer with running counters");

    // The bit slot never passes the acknowledge slot.
    a_bit_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_idx <= ACK_SLOT)
        else $error("bit slot out of range");

    // A result that is not taken stays put and blocks the next tick.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(r_out_data)))
        else $error("pending result lost");

    // The sequencer only moves on an accepted tick.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> ($stable(r_phase) && $stable(r_tick)))
        else $error("sequencer moved without a tick");

endmodule : i2c_master_byte_engine
`default_nettype wire
